// ----- rtl/fba_pkg.sv -----
// Package for the fit block allocator.
// Holds sizing constants, codes, the entry layout and the control types.
// No dependencies.
package fba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int BLK_AW     = $clog2(MAX_BLOCKS);
    localparam int NB_W       = BLK_AW + 1;
    localparam int CMP_W      = (NB_W > 7) ? NB_W : 7;

    localparam int SIZE_W  = 20;
    localparam int STAMP_W = 32;
    localparam int OVH_W   = 8;
    localparam int NUM_W   = 7;
    localparam int STAT_W  = 3;
    localparam int CIDX_W  = 2;

    localparam logic [SIZE_W-1:0] SIZE_MAX       = {SIZE_W{1'b1}};
    localparam logic [SIZE_W-1:0] TOTAL_RESET    = SIZE_W'(20000);
    localparam logic [OVH_W-1:0]  OVERHEAD_RESET = OVH_W'(16);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic FIT_FIRST = 1'b0;
    localparam logic FIT_BEST  = 1'b1;

    localparam logic [CIDX_W-1:0] CFG_FIT_MODE       = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_TOTAL_MEMORY   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_BLOCK_OVERHEAD = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        STAT_REUSED   = 3'd0,
        STAT_NEW      = 3'd1,
        STAT_FREED    = 3'd2,
        STAT_NO_MEM   = 3'd3,
        STAT_BAD_FREE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ALLOC,
        ST_FREE_CHK,
        ST_FREE_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  cap;
        logic [SIZE_W-1:0]  used;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic               valid;
        logic [STAMP_W-1:0] age;
        logic [SIZE_W-1:0]  waste;
    } pick_t;

endpackage

// ----- rtl/fba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/fba_pick.sv -----
// Fit compare for one candidate block against the current best pick.
// Depends on fba_pkg.
module fba_pick
    import fba_pkg::*;
(
    input  logic               fit_mode,
    input  logic [SIZE_W-1:0]  size,
    input  logic [STAMP_W-1:0] stamp_count,
    input  logic               is_free,
    input  logic [SIZE_W-1:0]  cap,
    input  logic [STAMP_W-1:0] stamp,
    input  pick_t              best,
    output pick_t              cand,
    output logic               take
);

    logic better;

    always_comb
    begin
        cand.valid = is_free && (cap >= size);
        cand.age   = stamp_count - stamp;
        cand.waste = cap - size;
        if (fit_mode == FIT_FIRST)
        begin
            better = cand.age > best.age;
        end
        else
        begin
            better = (cand.waste < best.waste) ||
                     ((cand.waste == best.waste) && (cand.age < best.age));
        end
        take = cand.valid && (!best.valid || better);
    end

endmodule

// ----- rtl/fit_block_allocator.sv -----
// Fit block allocator, first fit or best fit over a table of MAX_BLOCKS entries.
// Allocate: one scan of the entry RAM, one entry per cycle, through the shared fit compare,
// then the ALLOC step that writes the pick and the FINISH step that presents the result.
// Free: FREE_CHK, FREE_WR and FINISH; a rejected free skips FREE_WR. One request at a time;
// input is taken again once the result is presented; a result-side stall holds the result back.
// Reset (rst_n, asynchronous, active low) clears control state and control registers at once;
// the entry RAM needs no clearing pass. Depends on fba_pkg, fba_ram and fba_pick.
module fit_block_allocator
    import fba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [SIZE_W-1:0]   request_size,
    input  logic [NUM_W-1:0]    block_number,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STAT_W-1:0]   status,
    output logic [NUM_W-1:0]    granted_block,
    output logic [SIZE_W-1:0]   available,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [SIZE_W-1:0]   cfg_data
);

    state_t state_reg, state_next;

    logic                  fit_mode_reg, fit_mode_next;
    logic [SIZE_W-1:0]     total_reg, total_next;
    logic [OVH_W-1:0]      overhead_reg, overhead_next;

    logic [MAX_BLOCKS-1:0] is_free_reg, is_free_next;
    logic [NB_W-1:0]       next_block_reg, next_block_next;
    logic [SIZE_W-1:0]     used_total_reg, used_total_next;
    logic [SIZE_W-1:0]     ovh_total_reg, ovh_total_next;
    logic [STAMP_W-1:0]    stamp_cnt_reg, stamp_cnt_next;
    logic [NB_W-1:0]       cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;

    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [NUM_W-1:0]      number_reg, number_next;
    pick_t                 best_reg, best_next;
    logic [BLK_AW-1:0]     best_idx_reg, best_idx_next;
    logic [SIZE_W-1:0]     best_cap_reg, best_cap_next;
    status_t               res_status_reg, res_status_next;
    logic [NUM_W-1:0]      res_granted_reg, res_granted_next;
    logic [STAT_W-1:0]     status_reg, status_next;
    logic [NUM_W-1:0]      granted_reg, granted_next;
    logic [SIZE_W-1:0]     avail_reg, avail_next;

    logic                  ram_we;
    logic [BLK_AW-1:0]     ram_waddr;
    entry_t                ram_wdata;
    logic [BLK_AW-1:0]     ram_raddr;
    entry_t                ram_rdata;

    pick_t                 cand;
    logic                  take;
    logic [BLK_AW-1:0]     cmp_idx;
    logic [CMP_W-1:0]      num_ext;
    logic [CMP_W-1:0]      nb_ext;
    logic [BLK_AW-1:0]     free_idx;
    logic                  bad_free;
    logic [SIZE_W:0]       spent;
    logic [SIZE_W:0]       used_sum;
    logic                  in_accept;
    logic                  out_free;

    fba_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_BLOCKS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fba_pick u_pick (
        .fit_mode    (fit_mode_reg),
        .size        (size_reg),
        .stamp_count (stamp_cnt_reg),
        .is_free     (is_free_reg[cmp_idx] && (cnt_reg != '0)),
        .cap         (ram_rdata.cap),
        .stamp       (ram_rdata.stamp),
        .best        (best_reg),
        .cand        (cand),
        .take        (take)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign cmp_idx  = BLK_AW'(cnt_reg - NB_W'(1));
    assign num_ext  = CMP_W'(number_reg);
    assign nb_ext   = CMP_W'(next_block_reg);
    assign free_idx = BLK_AW'(num_ext - CMP_W'(1));
    assign bad_free = (num_ext == '0) || (num_ext >= nb_ext) ||
                      (num_ext > CMP_W'(MAX_BLOCKS)) || is_free_reg[free_idx];
    assign spent    = {1'b0, ovh_total_reg} + {1'b0, used_total_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (command == CMD_ALLOC) ? ST_SCAN : ST_FREE_CHK;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == NB_W'(MAX_BLOCKS))
                begin
                    state_next = ST_ALLOC;
                end
            end
            ST_ALLOC:
            begin
                state_next = ST_FINISH;
            end
            ST_FREE_CHK:
            begin
                state_next = bad_free ? ST_FINISH : ST_FREE_WR;
            end
            ST_FREE_WR:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fit_mode_next    = fit_mode_reg;
        total_next       = total_reg;
        overhead_next    = overhead_reg;
        is_free_next     = is_free_reg;
        next_block_next  = next_block_reg;
        used_total_next  = used_total_reg;
        ovh_total_next   = ovh_total_reg;
        stamp_cnt_next   = stamp_cnt_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        size_next        = size_reg;
        number_next      = number_reg;
        best_next        = best_reg;
        best_idx_next    = best_idx_reg;
        best_cap_next    = best_cap_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        status_next      = status_reg;
        granted_next     = granted_reg;
        avail_next       = avail_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_raddr        = '0;
        used_sum         = '0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FIT_MODE:       fit_mode_next = cfg_data[0];
                CFG_TOTAL_MEMORY:   total_next    = cfg_data;
                CFG_BLOCK_OVERHEAD: overhead_next = cfg_data[OVH_W-1:0];
                default:            ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    size_next      = request_size;
                    number_next    = block_number;
                    cnt_next       = '0;
                    best_next      = '0;
                end
            end
            ST_SCAN:
            begin
                ram_raddr = cnt_reg[BLK_AW-1:0];
                cnt_next  = cnt_reg + NB_W'(1);
                if (take)
                begin
                    best_next     = cand;
                    best_idx_next = cmp_idx;
                    best_cap_next = ram_rdata.cap;
                end
            end
            ST_ALLOC:
            begin
                used_sum = {1'b0, used_total_reg} + {1'b0, size_reg};
                if (best_reg.valid)
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = best_idx_reg;
                    ram_wdata.cap    = best_cap_reg;
                    ram_wdata.used   = size_reg;
                    ram_wdata.stamp  = stamp_cnt_reg;
                    is_free_next[best_idx_reg] = 1'b0;
                    used_total_next  = used_sum[SIZE_W] ? SIZE_MAX : used_sum[SIZE_W-1:0];
                    res_status_next  = STAT_REUSED;
                    res_granted_next = NUM_W'({1'b0, best_idx_reg} + NB_W'(1));
                end
                else if ((next_block_reg <= NB_W'(MAX_BLOCKS)) &&
                         (spent < {1'b0, total_reg}) &&
                         ((({1'b0, total_reg} - spent)) >= {1'b0, size_reg}))
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = BLK_AW'(next_block_reg - NB_W'(1));
                    ram_wdata.cap    = size_reg;
                    ram_wdata.used   = size_reg;
                    ram_wdata.stamp  = stamp_cnt_reg;
                    used_total_next  = used_sum[SIZE_W] ? SIZE_MAX : used_sum[SIZE_W-1:0];
                    ovh_total_next   = ovh_total_reg + SIZE_W'(overhead_reg);
                    next_block_next  = next_block_reg + NB_W'(1);
                    res_status_next  = STAT_NEW;
                    res_granted_next = NUM_W'(next_block_reg);
                end
                else if ((size_reg == '0) && (next_block_reg <= NB_W'(MAX_BLOCKS)))
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = BLK_AW'(next_block_reg - NB_W'(1));
                    ram_wdata.cap    = size_reg;
                    ram_wdata.used   = size_reg;
                    ram_wdata.stamp  = stamp_cnt_reg;
                    ovh_total_next   = ovh_total_reg + SIZE_W'(overhead_reg);
                    next_block_next  = next_block_reg + NB_W'(1);
                    res_status_next  = STAT_NEW;
                    res_granted_next = NUM_W'(next_block_reg);
                end
                else
                begin
                    res_status_next  = STAT_NO_MEM;
                    res_granted_next = '0;
                end
            end
            ST_FREE_CHK:
            begin
                ram_raddr        = free_idx;
                res_granted_next = '0;
                if (bad_free)
                begin
                    res_status_next = STAT_BAD_FREE;
                end
            end
            ST_FREE_WR:
            begin
                ram_we          = 1'b1;
                ram_waddr       = free_idx;
                ram_wdata.cap   = ram_rdata.cap;
                ram_wdata.used  = '0;
                ram_wdata.stamp = stamp_cnt_reg;
                used_total_next = (used_total_reg > ram_rdata.used) ?
                                  (used_total_reg - ram_rdata.used) : '0;
                is_free_next[free_idx] = 1'b1;
                stamp_cnt_next  = stamp_cnt_reg + STAMP_W'(1);
                res_status_next = STAT_FREED;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    granted_next   = res_granted_reg;
                    avail_next     = (spent >= {1'b0, total_reg}) ? '0 :
                                     SIZE_W'({1'b0, total_reg} - spent);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fit_mode_reg   <= FIT_FIRST;
            total_reg      <= TOTAL_RESET;
            overhead_reg   <= OVERHEAD_RESET;
            is_free_reg    <= '0;
            next_block_reg <= NB_W'(1);
            used_total_reg <= '0;
            ovh_total_reg  <= '0;
            stamp_cnt_reg  <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            best_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            fit_mode_reg   <= fit_mode_next;
            total_reg      <= total_next;
            overhead_reg   <= overhead_next;
            is_free_reg    <= is_free_next;
            next_block_reg <= next_block_next;
            used_total_reg <= used_total_next;
            ovh_total_reg  <= ovh_total_next;
            stamp_cnt_reg  <= stamp_cnt_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            best_reg       <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg        <= size_next;
        number_reg      <= number_next;
        best_idx_reg    <= best_idx_next;
        best_cap_reg    <= best_cap_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        status_reg      <= status_next;
        granted_reg     <= granted_next;
        avail_reg       <= avail_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_block = granted_reg;
    assign available     = avail_reg;

endmodule
